FILE: src/spom_pkg.sv
// Shared types, sizes and helpers for the spiral-order matrix readout.
// No dependencies; the readout and its testbench import it.
package spom_pkg;

  // Matrix geometry
  localparam int MAX_DIM   = 64;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int TOT_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the ports and registers
  localparam int CFG_W     = 7;
  localparam int VALUE_W   = 32;
  localparam int OUT_IDX_W = 6;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;

  // Register map, indexed by paddr[PADDR_W-1:2]
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  // Clamp a programmed dimension into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: src/spom_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Standalone; no package needed.
module spom_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle while enabled
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: src/spiral_order_matrix_readout.sv
// Spiral-order matrix readout: loads a matrix row-major, returns it in spiral order.
// Uses spom_pkg and one spom_ram instance that holds the matrix.
// A read transaction shows its result (done) in the cycle after it is accepted.
// Throughput: one transaction per cycle unless busy, loads and reads alike; the single
// memory port takes either one write (load) or one read (spiral step) each cycle.
// Reset: synchronous; dimensions return to 1x1, the spiral and load pointer restart,
// busy is a registered copy of rst. Matrix contents are kept, undefined
// until loaded. The receiver cannot stall: each result is valid for exactly one cycle.
module spiral_order_matrix_readout
  import spom_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic signed [VALUE_W-1:0]   load_value,
  // result channel
  output logic                        done,
  output logic signed [VALUE_W-1:0]   elem_value,
  output logic [OUT_IDX_W-1:0]        elem_row,
  output logic [OUT_IDX_W-1:0]        elem_col,
  output logic                        is_last,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_W-1:0]          paddr,
  input  logic [APB_W-1:0]            pwdata,
  output logic [APB_W-1:0]            prdata,
  output logic                        pready
);

  // Configuration registers
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] col_count;
  logic [TOT_W-1:0] total;

  // Traversal state
  logic [ADDR_W-1:0] load_pos, load_pos_next;
  logic [DIM_W-1:0]  cur_row, cur_row_next;
  logic [DIM_W-1:0]  cur_col, cur_col_next;
  logic [DIM_W-1:0]  row_hi, row_hi_next;
  logic [DIM_W-1:0]  col_hi, col_hi_next;
  logic [DIM_W-1:0]  row_lo, row_lo_next;
  logic [DIM_W-1:0]  col_lo, col_lo_next;
  heading_t          heading, heading_next;
  logic [TOT_W-1:0]  emitted, emitted_next;

  logic              cfg_wr;
  logic              reg_idx;
  logic              accept;
  logic              rd;
  logic              ld;
  logic              last;
  logic              restart;
  logic [DIM_W-1:0]  rows;
  logic [DIM_W-1:0]  cols;
  logic [DIM_W-1:0]  new_rows;
  logic [DIM_W-1:0]  new_cols;
  logic [DIM_W-1:0]  rs_rows;
  logic [DIM_W-1:0]  rs_cols;
  logic [ADDR_W-1:0] ld_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [2*DIM_W:0]  rd_lin;
  logic [TOT_W:0]    ld_inc;
  logic [TOT_W:0]    emit_inc;
  logic [VALUE_W-1:0] ram_rdata;

  // Decode handshakes
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1];
  assign accept  = start & ~busy;
  assign rd      = accept & (func == FUNC_READ);
  assign ld      = accept & (func == FUNC_LOAD);

  // Effective dimensions, current and as set by a pending register write
  assign rows     = eff_dim(row_count);
  assign cols     = eff_dim(col_count);
  assign new_rows = (cfg_wr && reg_idx == REG_ROW_COUNT) ? eff_dim(pwdata[CFG_W-1:0]) : rows;
  assign new_cols = (cfg_wr && reg_idx == REG_COL_COUNT) ? eff_dim(pwdata[CFG_W-1:0]) : cols;
  assign rs_rows  = cfg_wr ? new_rows : rows;
  assign rs_cols  = cfg_wr ? new_cols : cols;

  // Register readback
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ROW_COUNT: prdata[CFG_W-1:0] = row_count;
      REG_COL_COUNT: prdata[CFG_W-1:0] = col_count;
      default:       prdata = '0;
    endcase
  end

  // Configuration registers and cached element count
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CFG_W'(1);
      col_count <= CFG_W'(1);
      total     <= TOT_W'(1);
    end else if (cfg_wr) begin
      if (reg_idx == REG_ROW_COUNT) begin
        row_count <= pwdata[CFG_W-1:0];
      end else begin
        col_count <= pwdata[CFG_W-1:0];
      end
      total <= TOT_W'(new_rows) * TOT_W'(new_cols);
    end
  end

  // Memory addresses for load and spiral read
  assign ld_addr  = (TOT_W'(load_pos) >= total) ? '0 : load_pos;
  assign ld_inc   = (TOT_W + 1)'(ld_addr) + 1'b1;
  assign rd_lin   = (2*DIM_W + 1)'(cur_row) * (2*DIM_W + 1)'(cols) + (2*DIM_W + 1)'(cur_col);
  assign rd_addr  = rd_lin[ADDR_W-1:0];
  assign emit_inc = (TOT_W + 1)'(emitted) + 1'b1;
  assign last     = emit_inc >= (TOT_W + 1)'(total);
  assign restart  = cfg_wr | ld | (rd & last);

  // Load pointer: wrap after the last element, clear on a register write
  always_comb begin
    load_pos_next = load_pos;
    if (cfg_wr) begin
      load_pos_next = '0;
    end else if (ld) begin
      load_pos_next = (ld_inc >= (TOT_W + 1)'(total)) ? '0 : ld_inc[ADDR_W-1:0];
    end
  end

  // Spiral walk: restart at bottom-right heading up, else step and turn at bounds
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    row_hi_next  = row_hi;
    col_hi_next  = col_hi;
    row_lo_next  = row_lo;
    col_lo_next  = col_lo;
    heading_next = heading;
    emitted_next = emitted;
    if (restart) begin
      cur_row_next = rs_rows - 1'b1;
      cur_col_next = rs_cols - 1'b1;
      row_hi_next  = rs_rows - 1'b1;
      col_hi_next  = rs_cols - 1'b1;
      row_lo_next  = '0;
      col_lo_next  = '0;
      heading_next = HEAD_UP;
      emitted_next = '0;
    end else if (rd) begin
      emitted_next = emit_inc[TOT_W-1:0];
      case (heading)
        HEAD_RIGHT: begin
          if (cur_col == col_hi) begin
            heading_next = HEAD_UP;
            row_hi_next  = row_hi - 1'b1;
            cur_row_next = cur_row - 1'b1;
          end else begin
            cur_col_next = cur_col + 1'b1;
          end
        end
        HEAD_DOWN: begin
          if (cur_row == row_hi) begin
            heading_next = HEAD_RIGHT;
            col_lo_next  = col_lo + 1'b1;
            cur_col_next = cur_col + 1'b1;
          end else begin
            cur_row_next = cur_row + 1'b1;
          end
        end
        HEAD_LEFT: begin
          if (cur_col == col_lo) begin
            heading_next = HEAD_DOWN;
            row_lo_next  = row_lo + 1'b1;
            cur_row_next = cur_row + 1'b1;
          end else begin
            cur_col_next = cur_col - 1'b1;
          end
        end
        HEAD_UP: begin
          if (cur_row == row_lo) begin
            heading_next = HEAD_LEFT;
            col_hi_next  = col_hi - 1'b1;
            cur_col_next = cur_col - 1'b1;
          end else begin
            cur_row_next = cur_row - 1'b1;
          end
        end
        default: heading_next = HEAD_UP;
      endcase
    end
  end

  // Traversal registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
      row_hi   <= '0;
      col_hi   <= '0;
      row_lo   <= '0;
      col_lo   <= '0;
      heading  <= HEAD_UP;
      emitted  <= '0;
    end else begin
      load_pos <= load_pos_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      row_hi   <= row_hi_next;
      col_hi   <= col_hi_next;
      row_lo   <= row_lo_next;
      col_lo   <= col_lo_next;
      heading  <= heading_next;
      emitted  <= emitted_next;
    end
  end

  // Hold off commands just after reset: busy is a registered copy of rst
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Matrix storage
  spom_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk   (clk),
    .en    (ld | rd),
    .we    (ld),
    .addr  (ld ? ld_addr : rd_addr),
    .wdata (load_value),
    .rdata (ram_rdata)
  );

  // Result strobe and coordinates, aligned with the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      elem_row <= cur_row[OUT_IDX_W-1:0];
      elem_col <= cur_col[OUT_IDX_W-1:0];
      is_last  <= last;
    end
  end

  assign elem_value = signed'(ram_rdata);

  // A result only follows an accepted read
  a_done_follows_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && func == FUNC_READ))
    else $error("result strobe without a read transaction");

  // Emitted count stays below the element count
  a_emitted_range: assert property (@(posedge clk) disable iff (rst)
    TOT_W'(emitted) < total)
    else $error("emitted count reached element count");

  // Load pointer stays inside the matrix
  a_load_pos_range: assert property (@(posedge clk) disable iff (rst)
    TOT_W'(load_pos) < total)
    else $error("load pointer beyond matrix");

  // The final element restarts the spiral
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    rd && last |=> emitted == '0 && heading == HEAD_UP)
    else $error("spiral did not restart after final element");

endmodule

FILE: bench/tb_spiral_order_matrix_readout.sv
`timescale 1ns / 100ps
// Self-checking testbench for spiral_order_matrix_readout: loads matrices row-major
// over the command port, reads them back in spiral order and checks every result.
// Depends on spom_pkg and the block's RTL only.
module tb_spiral_order_matrix_readout;
  import spom_pkg::*;

  // One expected spiral element
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [OUT_IDX_W-1:0]      row;
    logic [OUT_IDX_W-1:0]      col;
    logic                      tail;
  } spiral_elem_t;

  // Mirror of the matrix, the dimension registers and the spiral walk;
  // queues the element each read transaction must return.
  class spiral_mirror;
    logic [CFG_W-1:0]          row_reg;
    logic [CFG_W-1:0]          col_reg;
    logic signed [VALUE_W-1:0] cells [DEPTH];
    bit                        loaded [DEPTH];
    int                        load_pos;
    int                        cur_row, cur_col, row_hi, col_hi, row_lo, col_lo;
    int                        emitted;
    heading_t                  heading;
    spiral_elem_t              pending_elems [$];
    int                        mismatches, checked, loads, reads, settings;

    function new();
      row_reg = 1;
      col_reg = 1;
      load_pos = 0;
      restart();
    endfunction

    // Clamp a register value into 1..MAX_DIM
    function int dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function int total();
      return dim(row_reg) * dim(col_reg);
    endfunction

    // True once every cell of the current shape holds a loaded word
    function bit ready_to_read();
      for (int i = 0; i < total(); i++) begin
        if (!loaded[i]) return 0;
      end
      return 1;
    endfunction

    function void restart();
      cur_row = dim(row_reg) - 1;
      cur_col = dim(col_reg) - 1;
      row_hi = cur_row;
      col_hi = cur_col;
      row_lo = 0;
      col_lo = 0;
      heading = HEAD_UP;
      emitted = 0;
    endfunction

    // Advance one spiral position; pull the finished bound inward on a turn
    function void step_spiral();
      case (heading)
        HEAD_RIGHT: begin
          if (cur_col == col_hi) begin
            heading = HEAD_UP; row_hi--; cur_row--;
          end else cur_col++;
        end
        HEAD_DOWN: begin
          if (cur_row == row_hi) begin
            heading = HEAD_RIGHT; col_lo++; cur_col++;
          end else cur_row++;
        end
        HEAD_LEFT: begin
          if (cur_col == col_lo) begin
            heading = HEAD_DOWN; row_lo++; cur_row++;
          end else cur_col--;
        end
        default: begin
          if (cur_row == row_lo) begin
            heading = HEAD_LEFT; col_hi--; cur_col--;
          end else cur_row--;
        end
      endcase
    endfunction

    // Any register write restarts the walk and the load pointer
    function void set_reg(logic idx, logic [CFG_W-1:0] v);
      if (idx == REG_ROW_COUNT) row_reg = v;
      else col_reg = v;
      load_pos = 0;
      restart();
    endfunction

    // Note an accepted command transaction
    function void accept(func_t f, logic signed [VALUE_W-1:0] v);
      int rows, cols, tot;
      spiral_elem_t e;
      rows = dim(row_reg);
      cols = dim(col_reg);
      tot = rows * cols;
      if (f == FUNC_LOAD) begin
        if (load_pos >= tot) load_pos = 0;
        cells[load_pos] = v;
        loaded[load_pos] = 1;
        load_pos++;
        if (load_pos >= tot) load_pos = 0;
        restart();
        loads++;
      end else begin
        e.value = '0;
        if (cur_row >= 0 && cur_col >= 0 && cur_row < rows && cur_col < cols)
          e.value = cells[cur_row * cols + cur_col];
        e.row = cur_row[OUT_IDX_W-1:0];
        e.col = cur_col[OUT_IDX_W-1:0];
        e.tail = (emitted + 1 >= tot);
        pending_elems.push_back(e);
        if (e.tail) restart();
        else begin
          emitted++;
          step_spiral();
        end
        reads++;
      end
    endfunction

    // Check one result against the oldest expected element
    function void compare(logic signed [VALUE_W-1:0] v, logic [OUT_IDX_W-1:0] r,
                          logic [OUT_IDX_W-1:0] c, logic t);
      spiral_elem_t e;
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected result value %0d row %0d col %0d last %0b",
                 $time, v, r, c, t);
        mismatches++;
        return;
      end
      e = pending_elems.pop_front();
      checked++;
      if (v !== e.value) begin
        $display("%0t: elem_value expected %0d actual %0d", $time, e.value, v);
        mismatches++;
      end
      if (r !== e.row) begin
        $display("%0t: elem_row expected %0d actual %0d", $time, e.row, r);
        mismatches++;
      end
      if (c !== e.col) begin
        $display("%0t: elem_col expected %0d actual %0d", $time, e.col, c);
        mismatches++;
      end
      if (t !== e.tail) begin
        $display("%0t: is_last expected %0b actual %0b", $time, e.tail, t);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      func = FUNC_LOAD;
  logic signed [VALUE_W-1:0] load_value = '0;
  logic                      done;
  logic signed [VALUE_W-1:0] elem_value;
  logic [OUT_IDX_W-1:0]      elem_row;
  logic [OUT_IDX_W-1:0]      elem_col;
  logic                      is_last;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [APB_W-1:0]          pwdata = '0;
  logic [APB_W-1:0]          prdata;
  logic                      pready;

  spiral_mirror sb = new();

  spiral_order_matrix_readout u_dut (.*);

  always #1 clk = ~clk;

  // Check every result strobe
  always @(posedge clk) begin
    if (!rst && done) sb.compare(elem_value, elem_row, elem_col, is_last);
  end

  // Word with a bias toward the signed extremes, zero and all ones
  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Hold start until the block takes the transaction, then note it
  task automatic issue(func_t f, logic [VALUE_W-1:0] v);
    start <= 1'b1;
    func <= f;
    load_value <= v;
    do @(posedge clk); while (busy);
    sb.accept(f, v);
  endtask

  // Drop start for a random number of cycles, with junk on the payload
  task automatic maybe_pause(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      func <= 1'($urandom_range(1));
      load_value <= $urandom;
      @(posedge clk);
      while ($urandom_range(99) < pct) @(posedge clk);
    end
  endtask

  // Go idle and wait until every expected element has arrived
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_elems.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both dimension registers back to back over the APB port
  task automatic write_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    logic [APB_W-1:0] word;
    logic             idx;
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? REG_ROW_COUNT : REG_COL_COUNT;
      word = $urandom;
      word[CFG_W-1:0] = (i == 0) ? rows : cols;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= word;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_reg(idx, word[CFG_W-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.settings++;
  endtask

  // One dimension setting: fill the matrix, then mostly whole spirals
  task automatic run_phase(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                           int pct, int items);
    int    left, tot, n, pick;
    func_t f;
    settle();
    write_dims(rows, cols);
    left = items;
    while (left > 0) begin
      tot = sb.total();
      pick = $urandom_range(99);
      if (!sb.ready_to_read()) begin
        f = FUNC_LOAD; n = 1;
      end else if (pick < 65) begin
        f = FUNC_READ; n = tot + $urandom_range(0, 2);
      end else if (pick < 82) begin
        f = FUNC_READ; n = $urandom_range(1, tot);
      end else if (pick < 96) begin
        f = FUNC_LOAD; n = $urandom_range(1, 3);
      end else begin
        f = FUNC_LOAD; n = tot;
      end
      for (int k = 0; k < n && left > 0; k++) begin
        maybe_pause(pct);
        issue(f, rand_word());
        left--;
      end
    end
  endtask

  initial begin
    // Reset once
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset shape is 1x1, reads wrap on every item
    issue(FUNC_LOAD, 32'h7FFF_FFFF);
    issue(FUNC_READ, 32'h0);
    issue(FUNC_READ, 32'hFFFF_FFFF);
    issue(FUNC_LOAD, 32'h8000_0000);
    issue(FUNC_READ, 32'h0);

    // Directed: 2x3 with extreme words, full spiral plus wrap
    settle();
    write_dims(7'd2, 7'd3);
    issue(FUNC_LOAD, 32'h0000_0000);
    issue(FUNC_LOAD, 32'hFFFF_FFFF);
    issue(FUNC_LOAD, 32'h7FFF_FFFF);
    issue(FUNC_LOAD, 32'h8000_0000);
    issue(FUNC_LOAD, 32'h5555_5555);
    issue(FUNC_LOAD, 32'hAAAA_AAAA);
    repeat (7) issue(FUNC_READ, $urandom);
    // Load past the end wraps to the first cell and restarts the walk
    issue(FUNC_LOAD, 32'h1234_5678);
    repeat (3) issue(FUNC_READ, $urandom);

    // Random phases; the receiver cannot stall, so only the sender idles
    run_phase(7'd0,   7'd0,   0,  40);
    run_phase(7'd64,  7'd1,   86, 150);
    run_phase(7'd1,   7'd64,  0,  150);
    run_phase(7'd127, 7'd2,   15, 260);
    run_phase(7'd2,   7'd127, 86, 150);
    run_phase(7'd5,   7'd7,   0,  120);
    run_phase(7'd4,   7'd4,   15, 80);
    run_phase(7'd7,   7'd3,   86, 60);
    for (int p = 0; p < 4; p++) begin
      run_phase(CFG_W'($urandom_range(1, 9)), CFG_W'($urandom_range(1, 9)),
                (p % 2 == 0) ? 0 : 86, 40);
    end
    settle();

    $display("Covered %0d loads and %0d spiral reads over %0d dimension settings,",
             sb.loads, sb.reads, sb.settings);
    $display("checked %0d elements with %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_elems.size() == 0) begin
      $display("PASS spiral_order_matrix_readout");
    end else begin
      if (sb.pending_elems.size() != 0)
        $display("%0d expected elements never arrived", sb.pending_elems.size());
      $display("FAIL spiral_order_matrix_readout");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #400_000;
    $display("Timeout with %0d elements outstanding", sb.pending_elems.size());
    $display("FAIL spiral_order_matrix_readout");
    $finish;
  end

endmodule

FILE: spiral_order_matrix_readout.f
src/spom_pkg.sv
src/spom_ram.sv
src/spiral_order_matrix_readout.sv
bench/tb_spiral_order_matrix_readout.sv
